/* src/lpd_pkg.sv */
// lpd_pkg: shared constants for the length-prefixed deframer
// command and result codes, header size and header counter width; no dependencies
package lpd_pkg;

    // number of bytes in the little-endian length header
    localparam int HEADER_BYTES = 4;

    // header byte counter, wide enough for positions up to eight bytes
    localparam int HDR_CNT_W = 3;

    // command codes of an input transaction
    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_LINKERR = 2'd2;

    // kind codes of a result transaction
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_LINKERR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_LIMIT   = 2'd2;

    // one result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [31:0] frame_length;
    } result_t;

endpackage

/* src/length_prefixed_deframer.sv */
// length_prefixed_deframer: top level of the byte-stream frame splitter
// uses lpd_pkg for codes, header size and the result struct
//
// Takes one input transaction per cycle (a received byte, a receive-timeout
// quantum or a link error) and gives at most one result transaction for each:
// every payload byte with its frame length and a last marker, one empty-frame
// result for a zero-length header, a total-timeout result (if enabled) once the
// accumulated quanta reach timeout_limit, and a link-error result that also
// drops any partial frame. An accepted item sits in the input register until
// the processing stage moves, which loads its result into the result register;
// the sustained rate is one item per cycle while results are taken, and the
// only limit is the single-entry result register, which holds the pipe while
// a result waits and out_ready is low. Header and timeout items that produce
// no result still pass through the input register and the processing stage.
// Configuration writes take effect at the next edge and are meant to be done
// while the block is idle.
module length_prefixed_deframer
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,

    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic        last_of_frame,
    output logic [31:0] frame_length
);

    localparam int HDR_W = lpd_pkg::HDR_CNT_W;

    // configuration registers
    logic        timeout_enable_reg;
    logic [15:0] timeout_quantum_reg;
    logic [30:0] timeout_limit_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_byte_reg;

    // framing state
    logic [HDR_W-1:0] header_count_reg, header_count_next;
    logic [31:0]      length_word_reg, length_word_next;
    logic             in_payload_reg, in_payload_next;
    logic [31:0]      payload_count_reg, payload_count_next;
    logic [31:0]      timeout_accum_reg, timeout_accum_next;

    // result register
    logic                 out_valid_reg;
    lpd_pkg::result_t     out_reg;

    // processing stage outputs
    logic                 res_valid;
    lpd_pkg::result_t     res;
    logic                 advance;

    // header assembly helpers
    logic [31:0]      hdr_base;
    logic [31:0]      hdr_lane;
    logic [31:0]      hdr_word;
    logic [HDR_W:0]   hdr_pos_inc;
    logic             hdr_done;

    // payload helpers
    logic [31:0]      cnt_inc;
    logic             pay_last;

    // timeout helpers
    logic [32:0]      tmo_sum;
    logic [31:0]      tmo_sat;
    logic             tmo_hit;

    // the processing stage moves when its result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign payload_byte  = out_reg.payload_byte;
    assign last_of_frame = out_reg.last_of_frame;
    assign frame_length  = out_reg.frame_length;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_enable_reg  <= 1'b0;
            timeout_quantum_reg <= '0;
            timeout_limit_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lpd_pkg::CFG_TIMEOUT_ENABLE:  timeout_enable_reg  <= cfg_data[0];
                lpd_pkg::CFG_TIMEOUT_QUANTUM: timeout_quantum_reg <= cfg_data[15:0];
                lpd_pkg::CFG_TIMEOUT_LIMIT:   timeout_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_cmd_reg  <= command;
            in_byte_reg <= data_byte;
        end
    end

    // header byte goes to its own lane; a new header starts from zero,
    // positions beyond the 32-bit word are consumed without effect
    always_comb
    begin
        hdr_base    = (header_count_reg == '0) ? 32'd0 : length_word_reg;
        hdr_lane    = {24'd0, in_byte_reg} << {header_count_reg[1:0], 3'b000};
        hdr_word    = (header_count_reg < HDR_W'(4)) ? (hdr_base | hdr_lane) : hdr_base;
        hdr_pos_inc = {1'b0, header_count_reg} + (HDR_W+1)'(1);
        hdr_done    = hdr_pos_inc >= (HDR_W+1)'(lpd_pkg::HEADER_BYTES);
    end

    assign cnt_inc  = payload_count_reg + 32'd1;
    assign pay_last = (cnt_inc == length_word_reg);

    // saturating add of the quantum, then compare with the limit
    assign tmo_sum = {1'b0, timeout_accum_reg} + {17'd0, timeout_quantum_reg};
    assign tmo_sat = tmo_sum[32] ? 32'hFFFF_FFFF : tmo_sum[31:0];
    assign tmo_hit = (tmo_sat >= {1'b0, timeout_limit_reg});

    // processing stage: next framing state and the result of this transaction
    always_comb
    begin
        header_count_next  = header_count_reg;
        length_word_next   = length_word_reg;
        in_payload_next    = in_payload_reg;
        payload_count_next = payload_count_reg;
        timeout_accum_next = timeout_accum_reg;
        res_valid          = 1'b0;
        res                = '0;

        unique case (in_cmd_reg)
            lpd_pkg::CMD_BYTE:
            begin
                if (!in_payload_reg)
                begin
                    length_word_next = hdr_word;
                    if (hdr_done)
                    begin
                        header_count_next = '0;
                        if (hdr_word == 32'd0)
                        begin
                            // zero-length header gives an empty frame
                            res_valid          = 1'b1;
                            res.kind           = lpd_pkg::KIND_EMPTY;
                            timeout_accum_next = '0;
                        end
                        else
                        begin
                            in_payload_next    = 1'b1;
                            payload_count_next = '0;
                        end
                    end
                    else
                    begin
                        header_count_next = hdr_pos_inc[HDR_W-1:0];
                    end
                end
                else
                begin
                    res_valid          = 1'b1;
                    res.kind           = lpd_pkg::KIND_PAYLOAD;
                    res.payload_byte   = in_byte_reg;
                    res.last_of_frame  = pay_last;
                    res.frame_length   = length_word_reg;
                    payload_count_next = cnt_inc;
                    if (pay_last)
                    begin
                        header_count_next  = '0;
                        length_word_next   = '0;
                        in_payload_next    = 1'b0;
                        payload_count_next = '0;
                        timeout_accum_next = '0;
                    end
                end
            end
            lpd_pkg::CMD_TIMEOUT:
            begin
                // partial frame is kept, only the accumulator moves
                if (timeout_enable_reg)
                begin
                    if (tmo_hit)
                    begin
                        timeout_accum_next = '0;
                        res_valid          = 1'b1;
                        res.kind           = lpd_pkg::KIND_TIMEOUT;
                    end
                    else
                    begin
                        timeout_accum_next = tmo_sat;
                    end
                end
            end
            lpd_pkg::CMD_LINKERR:
            begin
                header_count_next  = '0;
                length_word_next   = '0;
                in_payload_next    = 1'b0;
                payload_count_next = '0;
                timeout_accum_next = '0;
                res_valid          = 1'b1;
                res.kind           = lpd_pkg::KIND_LINKERR;
            end
            default: ; // unused command: no result, no state change
        endcase
    end

    // framing state registers, updated only when the stage moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= '0;
            length_word_reg   <= '0;
            in_payload_reg    <= 1'b0;
            payload_count_reg <= '0;
            timeout_accum_reg <= '0;
        end
        else if (advance)
        begin
            header_count_reg  <= header_count_next;
            length_word_reg   <= length_word_next;
            in_payload_reg    <= in_payload_next;
            payload_count_reg <= payload_count_next;
            timeout_accum_reg <= timeout_accum_next;
        end
    end

    // result register: loaded when the stage moves, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

endmodule
